### design/mdic_pkg.sv
package mdic_pkg;

   // default geometry
   localparam int MAX_DIMS_DEF    = 4;
   localparam int INDEX_WIDTH_DEF = 16;

   // fixed field widths
   localparam int NUM_RANGE_REGS = 4;
   localparam int DIM_COUNT_W    = 3;
   localparam int RANGE_W        = 16;
   localparam int INDEX_FIELD_W  = 16;
   localparam int FLAT_W         = 64;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 16;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_DIM_COUNT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_0   = 3'd1;

   localparam logic [DIM_COUNT_W-1:0] DIM_COUNT_RESET = 3'd4;
   localparam logic [RANGE_W-1:0]     RANGE_RESET     = 16'd1;

   typedef struct packed {
      logic in_range;
      logic last_tuple;
   } walk_flags_type;

endpackage

### design/mdic_walk.sv
module mdic_walk #(
   parameter int NUM_DIMS    = mdic_pkg::MAX_DIMS_DEF,
   parameter int INDEX_WIDTH = mdic_pkg::INDEX_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 take,
   input  logic                                 restart,
   input  logic [mdic_pkg::DIM_COUNT_W-1:0]     dim_count,
   input  logic [mdic_pkg::RANGE_W-1:0]         range_val [NUM_DIMS],
   output logic [INDEX_WIDTH-1:0]               tuple_idx [NUM_DIMS],
   output logic [INDEX_WIDTH:0]                 tuple_mul [NUM_DIMS],
   output mdic_pkg::walk_flags_type             tuple_flags
);
   import mdic_pkg::*;

   localparam int EFF_W = INDEX_WIDTH + 1;
   localparam logic [RANGE_W:0] SPAN = (RANGE_W + 1)'(1) << INDEX_WIDTH;

   logic [INDEX_WIDTH-1:0] idx_ff [NUM_DIMS];
   logic [INDEX_WIDTH-1:0] idx_in [NUM_DIMS];
   logic                   done_ff, done_in;

   logic [DIM_COUNT_W-1:0] n_act;
   logic [NUM_DIMS-1:0]    active;
   logic [EFF_W-1:0]       eff [NUM_DIMS];
   logic                   ok, last;

   always_comb begin
      if (dim_count == '0) begin
         n_act = DIM_COUNT_W'(1);
      end else if (dim_count > DIM_COUNT_W'(NUM_DIMS)) begin
         n_act = DIM_COUNT_W'(NUM_DIMS);
      end else begin
         n_act = dim_count;
      end
   end

   // effective range, capped at the index span
   for (genvar d = 0; d < NUM_DIMS; d++) begin : g_eff
      logic [RANGE_W:0] r_ext;
      assign r_ext     = {1'b0, range_val[d]};
      assign eff[d]    = EFF_W'((r_ext > SPAN) ? SPAN : r_ext);
      assign active[d] = DIM_COUNT_W'(d) < n_act;
   end

   always_comb begin
      ok   = !done_ff;
      last = 1'b1;
      for (int d = 0; d < NUM_DIMS; d++) begin
         if (active[d]) begin
            if (eff[d] == '0 || EFF_W'(idx_ff[d]) >= eff[d]) begin
               ok = 1'b0;
            end else if (EFF_W'(idx_ff[d]) != eff[d] - EFF_W'(1)) begin
               last = 1'b0;
            end
         end
      end
   end

   // odometer step, carry ripples from the innermost active dimension
   always_comb begin
      logic             carry;
      logic [EFF_W-1:0] inc;
      idx_in  = idx_ff;
      done_in = done_ff;
      carry   = 1'b1;
      inc     = '0;
      if (take) begin
         if (restart) begin
            for (int d = 0; d < NUM_DIMS; d++) idx_in[d] = '0;
            done_in = 1'b0;
         end else if (!ok) begin
            done_in = 1'b1;
         end else begin
            for (int d = NUM_DIMS - 1; d >= 0; d--) begin
               if (active[d] && carry) begin
                  inc = EFF_W'(idx_ff[d]) + EFF_W'(1);
                  if (inc < eff[d]) begin
                     idx_in[d] = inc[INDEX_WIDTH-1:0];
                     carry     = 1'b0;
                  end else begin
                     idx_in[d] = '0;
                  end
               end
            end
            if (carry) begin
               for (int d = 0; d < NUM_DIMS; d++) idx_in[d] = '0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < NUM_DIMS; d++) idx_ff[d] <= '0;
         done_ff <= 1'b0;
      end else begin
         idx_ff  <= idx_in;
         done_ff <= done_in;
      end
   end

   // tuple for the flat-index pipeline; an inactive dim acts as range 1, index 0
   always_comb begin
      tuple_flags.in_range   = ok && !restart;
      tuple_flags.last_tuple = ok && !restart && last;
      for (int d = 0; d < NUM_DIMS; d++) begin
         tuple_idx[d] = (tuple_flags.in_range && active[d]) ? idx_ff[d] : '0;
         tuple_mul[d] = active[d] ? eff[d] : EFF_W'(1);
      end
   end

endmodule

### design/mdic_flat.sv
module mdic_flat #(
   parameter int NUM_DIMS    = mdic_pkg::MAX_DIMS_DEF,
   parameter int INDEX_WIDTH = mdic_pkg::INDEX_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [INDEX_WIDTH-1:0]           in_idx [NUM_DIMS],
   input  logic [INDEX_WIDTH:0]             in_mul [NUM_DIMS],
   input  mdic_pkg::walk_flags_type         in_flags,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [INDEX_WIDTH-1:0]           out_idx [NUM_DIMS],
   output logic [mdic_pkg::FLAT_W-1:0]      out_flat,
   output mdic_pkg::walk_flags_type         out_flags
);
   import mdic_pkg::*;

   // stage 0 captures the tuple, each later stage does one Horner step
   localparam int STAGES = NUM_DIMS;

   logic                   vld_ff   [STAGES];
   logic [STAGES-1:0]      adv;
   logic [FLAT_W-1:0]      acc_ff   [STAGES];
   logic [INDEX_WIDTH-1:0] idx_ff   [STAGES][NUM_DIMS];
   logic [INDEX_WIDTH:0]   mul_ff   [STAGES][NUM_DIMS];
   walk_flags_type         flags_ff [STAGES];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      if (k == STAGES - 1) begin : g_tail
         assign adv[k] = !vld_ff[k] || out_ready;
      end else begin : g_mid
         assign adv[k] = !vld_ff[k] || adv[k+1];
      end

      if (k == 0) begin : g_head
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else if (adv[k]) begin
               vld_ff[k] <= in_valid;
            end
         end

         always_ff @(posedge clock) begin
            if (adv[k] && in_valid) begin
               acc_ff[k]   <= FLAT_W'(in_idx[0]);
               idx_ff[k]   <= in_idx;
               mul_ff[k]   <= in_mul;
               flags_ff[k] <= in_flags;
            end
         end
      end else begin : g_mac
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end

         always_ff @(posedge clock) begin
            if (adv[k] && vld_ff[k-1]) begin
               acc_ff[k]   <= acc_ff[k-1] * FLAT_W'(mul_ff[k-1][k])
                              + FLAT_W'(idx_ff[k-1][k]);
               idx_ff[k]   <= idx_ff[k-1];
               mul_ff[k]   <= mul_ff[k-1];
               flags_ff[k] <= flags_ff[k-1];
            end
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = vld_ff[STAGES-1];
   assign out_idx   = idx_ff[STAGES-1];
   assign out_flat  = acc_ff[STAGES-1];
   assign out_flags = flags_ff[STAGES-1];

endmodule

### design/multi_dim_index_counter.sv
// Row-major nested-loop index generator over up to four dimensions. Each
// req transaction with req_restart low returns one rsp transaction holding
// the current index tuple, its row-major flat index and the in_range and
// last_tuple flags, then steps the tuple like an odometer (innermost active
// dimension first, carry rippling outward). A zero range in an active
// dimension, an index no longer below its range, or a carry out of the
// outermost dimension ends the walk; after that every advance answers with
// all-zero fields until a req transaction with req_restart high, which
// clears the indices and itself answers with all-zero fields. The tuple
// state updates in the accept cycle (a short carry chain), so back-to-back
// items see each other's effect. The flat index is built by a Horner
// pipeline: the first stage captures the tuple, each later stage does one
// multiply-add. Stages carry their own valid bit and fill bubbles, so
// req_ready stays high while any stage is free or the result is being
// taken. Rate: one transaction per cycle while req_ready is high.
// Configuration (csr_index): 0 dim_count (0 reads as 1, values above the
// dimension count are clamped), 1..4 range_0..range_3. Write csr only
// while no transaction is in flight; csr_ready is always high and writes
// to other indexes are dropped.
module multi_dim_index_counter #(
   parameter int MAX_DIMS    = mdic_pkg::MAX_DIMS_DEF,
   parameter int INDEX_WIDTH = mdic_pkg::INDEX_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mdic_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mdic_pkg::CSR_DATA_W-1:0]      csr_data,
   // request
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_restart,
   // response
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [mdic_pkg::INDEX_FIELD_W-1:0]   rsp_index_0,
   output logic [mdic_pkg::INDEX_FIELD_W-1:0]   rsp_index_1,
   output logic [mdic_pkg::INDEX_FIELD_W-1:0]   rsp_index_2,
   output logic [mdic_pkg::INDEX_FIELD_W-1:0]   rsp_index_3,
   output logic [mdic_pkg::FLAT_W-1:0]          rsp_flat_index,
   output logic                                 rsp_in_range,
   output logic                                 rsp_last_tuple
);
   import mdic_pkg::*;

   // dimensions that actually exist: bounded by the range registers
   localparam int NUM_DIMS = (MAX_DIMS < NUM_RANGE_REGS) ? MAX_DIMS : NUM_RANGE_REGS;

   logic [DIM_COUNT_W-1:0] dim_count_ff;
   logic [RANGE_W-1:0]     range_ff [NUM_DIMS];
   logic                   csr_write;

   logic [INDEX_WIDTH-1:0] tuple_idx [NUM_DIMS];
   logic [INDEX_WIDTH:0]   tuple_mul [NUM_DIMS];
   walk_flags_type         tuple_flags;

   logic [INDEX_WIDTH-1:0] out_idx [NUM_DIMS];
   walk_flags_type         out_flags;
   logic [INDEX_FIELD_W-1:0] index_field [NUM_RANGE_REGS];

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_count_ff <= DIM_COUNT_RESET;
         for (int d = 0; d < NUM_DIMS; d++) range_ff[d] <= RANGE_RESET;
      end else if (csr_write) begin
         if (csr_index == CSR_DIM_COUNT) begin
            dim_count_ff <= csr_data[DIM_COUNT_W-1:0];
         end
         for (int d = 0; d < NUM_DIMS; d++) begin
            if (csr_index == CSR_RANGE_0 + CSR_INDEX_W'(d)) begin
               range_ff[d] <= csr_data[RANGE_W-1:0];
            end
         end
      end
   end

   // tuple state and odometer step
   mdic_walk #(
      .NUM_DIMS    (NUM_DIMS),
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_walk (
      .clock       (clock),
      .reset       (reset),
      .take        (req_valid && req_ready),
      .restart     (req_restart),
      .dim_count   (dim_count_ff),
      .range_val   (range_ff),
      .tuple_idx   (tuple_idx),
      .tuple_mul   (tuple_mul),
      .tuple_flags (tuple_flags)
   );

   // flat-index pipeline, doubles as the output register
   mdic_flat #(
      .NUM_DIMS    (NUM_DIMS),
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_flat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_idx    (tuple_idx),
      .in_mul    (tuple_mul),
      .in_flags  (tuple_flags),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_idx   (out_idx),
      .out_flat  (rsp_flat_index),
      .out_flags (out_flags)
   );

   // dimensions that do not exist read as zero
   for (genvar d = 0; d < NUM_RANGE_REGS; d++) begin : g_field
      if (d < NUM_DIMS) begin : g_on
         assign index_field[d] = INDEX_FIELD_W'(out_idx[d]);
      end else begin : g_off
         assign index_field[d] = '0;
      end
   end

   assign rsp_index_0    = index_field[0];
   assign rsp_index_1    = index_field[1];
   assign rsp_index_2    = index_field[2];
   assign rsp_index_3    = index_field[3];
   assign rsp_in_range   = out_flags.in_range;
   assign rsp_last_tuple = out_flags.last_tuple;

endmodule

### design/mdic_checker.sv
module mdic_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 csr_valid,
   input logic                                 csr_ready,
   input logic [mdic_pkg::CSR_INDEX_W-1:0]     csr_index,
   input logic [mdic_pkg::CSR_DATA_W-1:0]      csr_data,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 req_restart,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [mdic_pkg::INDEX_FIELD_W-1:0]   rsp_index_0,
   input logic [mdic_pkg::INDEX_FIELD_W-1:0]   rsp_index_1,
   input logic [mdic_pkg::INDEX_FIELD_W-1:0]   rsp_index_2,
   input logic [mdic_pkg::INDEX_FIELD_W-1:0]   rsp_index_3,
   input logic [mdic_pkg::FLAT_W-1:0]          rsp_flat_index,
   input logic                                 rsp_in_range,
   input logic                                 rsp_last_tuple
);

   // stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_flat_index)
         && $stable(rsp_index_0) && $stable(rsp_in_range))
      else $error("rsp payload changed while stalled");

   // out-of-walk responses carry nothing
   a_zero_when_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_range |-> rsp_flat_index == '0 && rsp_index_0 == '0
         && rsp_index_1 == '0 && rsp_index_2 == '0 && rsp_index_3 == '0)
      else $error("nonzero fields on an out-of-range response");

   a_last_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_tuple |-> rsp_in_range)
      else $error("last_tuple without in_range");

   // taking the output lets every stage of the pipeline advance
   a_drain_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |-> req_ready)
      else $error("req_ready low while response is taken");

endmodule

bind multi_dim_index_counter mdic_checker u_mdic_checker (.*);

### tb/tb_multi_dim_index_counter.sv
module tb_multi_dim_index_counter;
   timeunit 1ns;
   timeprecision 1ps;

   import mdic_pkg::*;

   // Pipeline depth is min(MAX_DIMS, 4) = 4; the settle time after a drain adds margin.
   localparam int SETTLE_CYCLES  = 8;
   // Cycles with no transaction on any channel before the run is declared hung.
   localparam int QUIET_LIMIT    = 5000;
   localparam int REQUEST_TARGET = 1650;
   localparam int DIM_COUNT_MAX  = 2**DIM_COUNT_W - 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_UNUSED =
      CSR_INDEX_W'(CSR_RANGE_0 + NUM_RANGE_REGS);
   localparam logic [RANGE_W-1:0]     RANGE_FULL       = '1;

   // One response: the tuple, its flat position and the walk flags.
   typedef struct packed {
      logic [INDEX_FIELD_W-1:0] index_0;
      logic [INDEX_FIELD_W-1:0] index_1;
      logic [INDEX_FIELD_W-1:0] index_2;
      logic [INDEX_FIELD_W-1:0] index_3;
      logic [FLAT_W-1:0]        flat_index;
      walk_flags_type           flags;
   } tuple_report_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]     csr_data;
   logic                      req_valid;
   logic                      req_ready;
   logic                      req_restart;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [INDEX_FIELD_W-1:0]  rsp_index_0;
   logic [INDEX_FIELD_W-1:0]  rsp_index_1;
   logic [INDEX_FIELD_W-1:0]  rsp_index_2;
   logic [INDEX_FIELD_W-1:0]  rsp_index_3;
   logic [FLAT_W-1:0]         rsp_flat_index;
   logic                      rsp_in_range;
   logic                      rsp_last_tuple;

   multi_dim_index_counter u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_restart    (req_restart),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_index_0    (rsp_index_0),
      .rsp_index_1    (rsp_index_1),
      .rsp_index_2    (rsp_index_2),
      .rsp_index_3    (rsp_index_3),
      .rsp_flat_index (rsp_flat_index),
      .rsp_in_range   (rsp_in_range),
      .rsp_last_tuple (rsp_last_tuple)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Odometer shadow: configuration copy plus walk state, updated at each accept.
   // ---------------------------------------------------------------------------
   logic [DIM_COUNT_W-1:0]   cfg_dim_count;
   logic [RANGE_W-1:0]       cfg_range [NUM_RANGE_REGS];
   logic [INDEX_FIELD_W-1:0] odo_idx   [NUM_RANGE_REGS];
   logic                     walk_done;

   tuple_report_type expected_tuples[$];
   tuple_report_type want_tuple;
   tuple_report_type got_tuple;

   int err_count    = 0;
   int n_requests   = 0;
   int n_restarts   = 0;
   int n_in_range   = 0;
   int n_last       = 0;
   int n_walk_ends  = 0;
   int n_csr_writes = 0;
   int n_responses  = 0;
   int burst_left   = 0;
   int quiet_cycles = 0;
   int stall_mode   = 0;
   int stall_timer  = 0;

   // dim_count of zero acts as one, anything above the dimension count is clamped
   function automatic int active_dims();
      if (cfg_dim_count == 0) return 1;
      if (cfg_dim_count > MAX_DIMS_DEF) return MAX_DIMS_DEF;
      return int'(cfg_dim_count);
   endfunction

   function automatic tuple_report_type step_odometer(input logic restart_bit);
      tuple_report_type rpt;
      int               n;
      logic             ok;
      logic             at_end;
      logic             carry;
      rpt    = '0;
      n      = active_dims();
      ok     = !walk_done;
      at_end = 1'b1;
      if (restart_bit) begin
         // restart clears the tuple and answers with an all-zero report
         foreach (odo_idx[d]) odo_idx[d] = '0;
         walk_done = 1'b0;
         n_restarts++;
         return rpt;
      end
      for (int d = 0; d < n; d++) begin
         if (cfg_range[d] == 0 || odo_idx[d] >= cfg_range[d]) ok = 1'b0;
         else if (int'(odo_idx[d]) != int'(cfg_range[d]) - 1) at_end = 1'b0;
      end
      if (!ok) begin
         // finished walk, zero range or index no longer below a shrunk range
         walk_done = 1'b1;
         n_walk_ends++;
         return rpt;
      end
      for (int d = 0; d < n; d++)
         rpt.flat_index = rpt.flat_index * cfg_range[d] + odo_idx[d];
      rpt.index_0          = odo_idx[0];
      rpt.index_1          = (n > 1) ? odo_idx[1] : '0;
      rpt.index_2          = (n > 2) ? odo_idx[2] : '0;
      rpt.index_3          = (n > 3) ? odo_idx[3] : '0;
      rpt.flags.in_range   = 1'b1;
      rpt.flags.last_tuple = at_end;
      n_in_range++;
      if (at_end) n_last++;
      // innermost active dimension first, carry ripples outward
      carry = 1'b1;
      for (int d = n - 1; d >= 0 && carry; d--) begin
         if (int'(odo_idx[d]) + 1 < int'(cfg_range[d])) begin
            odo_idx[d] = odo_idx[d] + 1'b1;
            carry      = 1'b0;
         end else begin
            odo_idx[d] = '0;
         end
      end
      if (carry) begin
         foreach (odo_idx[d]) odo_idx[d] = '0;
         walk_done = 1'b1;
      end
      return rpt;
   endfunction

   // ---------------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------------
   task automatic flag_error(input string msg);
      err_count++;
      if (err_count <= 10) $display("[%0t] ERROR: %s", $realtime, msg);
   endtask

   // One request transaction. Bursts of random length, random gaps between them.
   task automatic send_request(input logic restart_bit);
      int gap;
      csr_valid <= 1'b0;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_restart <= restart_bit;
      do @(posedge clock); while (!req_ready);
      expected_tuples.push_back(step_odometer(restart_bit));
      n_requests++;
   endtask

   // Register write transaction; the shadow copy updates on accept.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0]  data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_DIM_COUNT)
         cfg_dim_count = data[DIM_COUNT_W-1:0];
      else if (idx >= CSR_RANGE_0 && idx < CSR_FIRST_UNUSED)
         cfg_range[idx - CSR_RANGE_0] = data[RANGE_W-1:0];
      n_csr_writes++;
   endtask

   task automatic set_geometry(input logic [CSR_DATA_W-1:0] dims,
                               input logic [RANGE_W-1:0] r0, input logic [RANGE_W-1:0] r1,
                               input logic [RANGE_W-1:0] r2, input logic [RANGE_W-1:0] r3);
      write_csr(CSR_DIM_COUNT, dims);
      write_csr(CSR_RANGE_0, r0);
      write_csr(CSR_INDEX_W'(CSR_RANGE_0 + 1), r1);
      write_csr(CSR_INDEX_W'(CSR_RANGE_0 + 2), r2);
      write_csr(CSR_INDEX_W'(CSR_RANGE_0 + 3), r3);
   endtask

   // Stop issuing, let every outstanding response come back, then let the
   // pipeline settle so a register write cannot hit an item in flight.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      burst_left = 0;
      while (expected_tuples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Response check and receiver stall pattern
   // ---------------------------------------------------------------------------
   task automatic compare_field(input string name, input logic [FLAT_W-1:0] want,
                                input logic [FLAT_W-1:0] got);
      if (got !== want)
         flag_error($sformatf("response %0d %s: expected 0x%0h, got 0x%0h",
                              n_responses, name, want, got));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_tuple = '{rsp_index_0, rsp_index_1, rsp_index_2, rsp_index_3,
                          rsp_flat_index, '{rsp_in_range, rsp_last_tuple}};
            if (expected_tuples.size() == 0) begin
               flag_error($sformatf("response %0d arrived with nothing outstanding",
                                    n_responses));
            end else begin
               want_tuple = expected_tuples.pop_front();
               compare_field("index_0", FLAT_W'(want_tuple.index_0),
                             FLAT_W'(got_tuple.index_0));
               compare_field("index_1", FLAT_W'(want_tuple.index_1),
                             FLAT_W'(got_tuple.index_1));
               compare_field("index_2", FLAT_W'(want_tuple.index_2),
                             FLAT_W'(got_tuple.index_2));
               compare_field("index_3", FLAT_W'(want_tuple.index_3),
                             FLAT_W'(got_tuple.index_3));
               compare_field("flat_index", want_tuple.flat_index, got_tuple.flat_index);
               compare_field("in_range", FLAT_W'(want_tuple.flags.in_range),
                             FLAT_W'(got_tuple.flags.in_range));
               compare_field("last_tuple", FLAT_W'(want_tuple.flags.last_tuple),
                             FLAT_W'(got_tuple.flags.last_tuple));
            end
            n_responses++;
         end
         // stall modes: always ready, mostly ready, periodic, long stalls
         if (stall_timer == 0) begin
            stall_mode  = $urandom_range(0, 3);
            stall_timer = $urandom_range(50, 300);
         end
         stall_timer--;
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 9) < 7);
            2: rsp_ready <= (stall_timer % 5 != 0);
            default: rsp_ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // Hang detection: count cycles with no transaction on any channel.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] ERROR: no transaction for %0d cycles, %0d responses outstanding",
                     $realtime, QUIET_LIMIT, expected_tuples.size());
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Reset geometry is four dimensions of range one: a single tuple, then the
   // walk is over until a restart.
   task automatic test_reset_state();
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b1);
      send_request(1'b0);
   endtask

   // dim_count zero and above the limit, unused register indexes, zero range,
   // full-width ranges.
   task automatic test_register_extremes();
      drain_pipeline();
      // dim_count zero acts as one; inactive zero ranges must not matter
      set_geometry(16'hFFF8, 16'd3, 16'd0, 16'd0, 16'd0);
      send_request(1'b1);
      repeat (4) send_request(1'b0);
      drain_pipeline();
      // clamped dim_count; writes past the range registers are dropped
      set_geometry(CSR_DATA_W'(DIM_COUNT_MAX), 16'd1, 16'd1, 16'd2, 16'd2);
      for (int i = CSR_FIRST_UNUSED; i <= DIM_COUNT_MAX; i++)
         write_csr(CSR_INDEX_W'(i), 16'hFFFF);
      send_request(1'b1);
      repeat (5) send_request(1'b0);
      drain_pipeline();
      // a zero range in an active dimension ends the walk at once
      set_geometry(CSR_DATA_W'(MAX_DIMS_DEF), 16'd5, 16'd5, 16'd0, 16'd5);
      send_request(1'b1);
      send_request(1'b0);
      drain_pipeline();
      set_geometry(CSR_DATA_W'(MAX_DIMS_DEF), RANGE_FULL, RANGE_FULL, RANGE_FULL,
                   RANGE_FULL);
      send_request(1'b1);
      repeat (2) send_request(1'b0);
   endtask

   // Step each dimension on its own by narrowing dim_count, so every index
   // holds a sizable value, then widen again under large ranges to push the
   // flat index into its upper bits. Last round shrinks one range to at most
   // its index to end the walk mid-way.
   task automatic test_deep_indices();
      logic [RANGE_W-1:0] r;
      int                 sel;
      drain_pipeline();
      set_geometry(CSR_DATA_W'(MAX_DIMS_DEF), RANGE_FULL, RANGE_FULL, RANGE_FULL,
                   RANGE_FULL);
      send_request(1'b1);
      for (int d = 0; d < NUM_RANGE_REGS; d++) begin
         drain_pipeline();
         write_csr(CSR_DIM_COUNT, CSR_DATA_W'(d + 1));
         repeat ($urandom_range(1, 150)) send_request(1'b0);
      end
      for (int round = 0; round < 5; round++) begin
         drain_pipeline();
         write_csr(CSR_DIM_COUNT, ($urandom_range(0, 3) == 0)
                   ? CSR_DATA_W'($urandom_range(MAX_DIMS_DEF + 1, DIM_COUNT_MAX))
                   : CSR_DATA_W'(MAX_DIMS_DEF));
         for (int d = 0; d < NUM_RANGE_REGS; d++) begin
            if (d < NUM_RANGE_REGS - 1 && $urandom_range(0, 3) == 0)
               r = odo_idx[d] + 1'b1;
            else
               r = RANGE_W'($urandom_range(int'(odo_idx[d]) + 1, 65535));
            write_csr(CSR_INDEX_W'(CSR_RANGE_0 + d), r);
         end
         if (round == 4) begin
            sel = int'($urandom_range(0, NUM_RANGE_REGS - 1));
            write_csr(CSR_INDEX_W'(CSR_RANGE_0 + sel),
                      CSR_DATA_W'($urandom_range(0, int'(odo_idx[sel]))));
         end
         repeat (16) send_request(1'b0);
      end
   endtask

   // Random geometries with mostly complete walks: restart, then about as
   // many advances as the walk has tuples. Some phases skip the restart so
   // the old tuple meets new ranges; a few stray restarts land mid-walk.
   task automatic test_random_walks();
      int                 n;
      int                 tuples;
      int                 cap;
      logic [RANGE_W-1:0] r;
      while (n_requests < REQUEST_TARGET) begin
         drain_pipeline();
         if ($urandom_range(0, 4) != 0)
            write_csr(CSR_DIM_COUNT, CSR_DATA_W'($urandom() & 32'hFFF8) |
                      (($urandom_range(0, 9) == 0)
                       ? CSR_DATA_W'($urandom_range(0, 1) ? 0
                                     : $urandom_range(MAX_DIMS_DEF + 1, DIM_COUNT_MAX))
                       : CSR_DATA_W'($urandom_range(1, MAX_DIMS_DEF))));
         cap = (active_dims() <= 2) ? 9 : 4;
         for (int d = 0; d < NUM_RANGE_REGS; d++) begin
            if ($urandom_range(0, 3) != 0) begin
               case ($urandom_range(0, 23))
                  0, 1:    r = '0;
                  2:       r = RANGE_FULL;
                  3:       r = RANGE_W'($urandom());
                  default: r = RANGE_W'($urandom_range(1, cap));
               endcase
               write_csr(CSR_INDEX_W'(CSR_RANGE_0 + d), r);
            end
         end
         if ($urandom_range(0, 7) == 0)
            write_csr(CSR_INDEX_W'($urandom_range(CSR_FIRST_UNUSED, DIM_COUNT_MAX)),
                      CSR_DATA_W'($urandom()));
         n      = active_dims();
         tuples = 1;
         for (int d = 0; d < n; d++) begin
            tuples = tuples * int'(cfg_range[d]);
            if (tuples > 64) tuples = 64;
         end
         if ($urandom_range(0, 3) != 0) send_request(1'b1);
         repeat (tuples + $urandom_range(0, 3))
            send_request($urandom_range(0, 39) == 0);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------
   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_restart = 1'b0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      rsp_ready   = 1'b0;
      cfg_dim_count = DIM_COUNT_RESET;
      foreach (cfg_range[d]) cfg_range[d] = RANGE_RESET;
      foreach (odo_idx[d]) odo_idx[d] = '0;
      walk_done = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_register_extremes();
      test_deep_indices();
      test_random_walks();
      drain_pipeline();

      if (expected_tuples.size() != 0)
         flag_error($sformatf("%0d responses never arrived", expected_tuples.size()));
      $display("Walked %0d request transactions (%0d restarts) over %0d register writes.",
               n_requests, n_restarts, n_csr_writes);
      $display("Saw %0d in-range tuples, %0d final tuples, %0d ended-walk reports.",
               n_in_range, n_last, n_walk_ends);
      if (err_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches in total", err_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
design/mdic_pkg.sv
design/mdic_walk.sv
design/mdic_flat.sv
design/multi_dim_index_counter.sv
design/mdic_checker.sv
tb/tb_multi_dim_index_counter.sv
